[rtl/sgb_pkg.sv]
`default_nettype none

package sgb_pkg;

   // Accumulator width for both filter passes (15 products of 16 x 16 bits plus rounding)
   localparam int ACC_BITS = 40;

   // Result queue depth
   localparam int OUT_DEPTH = 4;

   // Request op codes
   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   // Control register indexes
   typedef enum logic [2:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_KERNEL_RADIUS = 3'd2,
      CSR_WEIGHTS_LOW   = 3'd3,
      CSR_WEIGHTS_HIGH  = 3'd4
   } csr_index_type;

   // Work passed from the vertical pass to the horizontal sequencer
   typedef struct packed {
      logic        clear;
      logic        emit_main;
      logic [2:0]  tail;
      logic        frame_end;
      logic [15:0] orow;
      logic [9:0]  col;
   } tok_type;

   // One result
   typedef struct packed {
      logic [15:0] value;
      logic [15:0] out_row;
      logic [9:0]  out_col;
      logic        last;
      logic        frame_end;
   } rsp_type;

   // Pick the Q0.16 weight for kernel offset d
   function automatic logic [15:0] weight_at(input logic [63:0] lo, input logic [63:0] hi,
                                             input logic [2:0] d);
      logic [63:0] word;
      word = d[2] ? hi : lo;
      return word[d[1:0]*16 +: 16];
   endfunction

   // Round half up, drop 16 fraction bits, saturate, keep 16 bits
   function automatic logic [15:0] round_sat(input logic [ACC_BITS-1:0] acc,
                                             input logic [ACC_BITS-1:0] sat_max);
      logic [ACC_BITS-1:0] v;
      v = (acc + ACC_BITS'(32'h8000)) >> 16;
      if (v > sat_max) v = sat_max;
      return v[15:0];
   endfunction

endpackage

`default_nettype wire

[rtl/sgb_vert.sv]
`default_nettype none

module sgb_vert #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_RADIUS = 7,
   parameter int SAMPLE_BITS = 16,
   localparam int XW = $clog2(MAX_WIDTH),
   localparam int ROW_SLOTS = 2 * MAX_RADIUS,
   localparam int SLW = $clog2(ROW_SLOTS)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  in_valid,
   input  wire logic [XW-1:0]         in_addr,
   input  wire logic [SLW-1:0]        in_slot,
   input  wire logic [16:0]           in_row,
   input  wire logic [15:0]           in_sample,
   input  wire logic [2:0]            in_radius,
   input  wire sgb_pkg::tok_type      in_tok,
   input  wire logic [63:0]           weights_low,
   input  wire logic [63:0]           weights_high,
   output logic                       out_valid,
   output logic [15:0]                out_value,
   output sgb_pkg::tok_type           out_tok
);

   localparam int NT = ROW_SLOTS + 1;
   localparam int NG = (NT + 3) / 4;
   localparam int KW = SLW + 2;
   localparam int WW = ROW_SLOTS * 16;
   localparam logic [sgb_pkg::ACC_BITS-1:0] SAT_MAX =
      (sgb_pkg::ACC_BITS'(1) << SAMPLE_BITS) - sgb_pkg::ACC_BITS'(1);

   // Line store: one word per column holding every row slot
   logic [WW-1:0] mem [MAX_WIDTH];
   logic [WW-1:0] rd_ff;
   logic          fwd_ff;
   logic [WW-1:0] fwd_word_ff;

   logic                  s1_valid_ff;
   logic [XW-1:0]         s1_addr_ff;
   logic [SLW-1:0]        s1_slot_ff;
   logic [16:0]           s1_row_ff;
   logic [15:0]           s1_sample_ff;
   logic [2:0]            s1_radius_ff;
   sgb_pkg::tok_type      s1_tok_ff;

   logic                  s2_valid_ff;
   logic [31:0]           prod_ff [NT];
   logic [31:0]           prod_in [NT];
   sgb_pkg::tok_type      s2_tok_ff;

   logic                  s3_valid_ff;
   logic [sgb_pkg::ACC_BITS-1:0] grp_ff [NG];
   logic [sgb_pkg::ACC_BITS-1:0] grp_in [NG];
   sgb_pkg::tok_type      s3_tok_ff;

   logic [sgb_pkg::ACC_BITS-1:0] total;
   logic [WW-1:0] word;
   logic [WW-1:0] wr_word;

   // Read at accept, write back the updated column word when the request leaves stage 1
   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         rd_ff <= mem[in_addr];
         fwd_word_ff <= wr_word;
      end
      if (adv && s1_valid_ff) begin
         mem[s1_addr_ff] <= wr_word;
      end
   end

   // Forward the word being written when the next read hits the same column
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (adv && in_valid) begin
         fwd_ff <= s1_valid_ff && (s1_addr_ff == in_addr);
      end
   end

   // Merge the new sample into its row slot
   always_comb begin
      word = fwd_ff ? fwd_word_ff : rd_ff;
      wr_word = word;
      wr_word[s1_slot_ff*16 +: 16] = s1_sample_ff;
   end

   // Weight every stored row by its distance from the center row
   always_comb begin
      logic [KW-1:0] k;
      logic [KW-1:0] d;
      logic [KW-1:0] rk;
      logic          ok;
      logic [15:0]   w;
      rk = KW'(s1_radius_ff);
      for (int s = 0; s < ROW_SLOTS; s++) begin
         k = KW'(s1_slot_ff) + KW'(ROW_SLOTS) - KW'(s);
         if (k >= KW'(ROW_SLOTS)) k = k - KW'(ROW_SLOTS);
         if (k == '0) k = KW'(ROW_SLOTS);
         ok = (k <= (rk << 1)) && (s1_row_ff >= 17'(k));
         d = (k > rk) ? (k - rk) : (rk - k);
         w = ok ? sgb_pkg::weight_at(weights_low, weights_high, d[2:0]) : 16'd0;
         prod_in[s] = w * word[s*16 +: 16];
      end
      prod_in[ROW_SLOTS] = sgb_pkg::weight_at(weights_low, weights_high, s1_radius_ff)
                           * s1_sample_ff;
   end

   // Partial sums in groups of four
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_in[g] = '0;
         for (int i = 0; i < 4; i++) begin
            if (g * 4 + i < NT) grp_in[g] = grp_in[g] + sgb_pkg::ACC_BITS'(prod_ff[g*4+i]);
         end
      end
   end

   always_comb begin
      total = '0;
      for (int g = 0; g < NG; g++) total = total + grp_ff[g];
   end

   // Advance the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         out_valid <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         out_valid <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_addr_ff <= in_addr;
         s1_slot_ff <= in_slot;
         s1_row_ff <= in_row;
         s1_sample_ff <= in_sample;
         s1_radius_ff <= in_radius;
         s1_tok_ff <= in_tok;
         prod_ff <= prod_in;
         s2_tok_ff <= s1_tok_ff;
         grp_ff <= grp_in;
         s3_tok_ff <= s2_tok_ff;
         out_value <= sgb_pkg::round_sat(total, SAT_MAX);
         out_tok <= s3_tok_ff;
      end
   end

   // Valid bits move as one shift line
   assert property (@(posedge clock) disable iff (reset)
      adv && s1_valid_ff |=> s2_valid_ff)
      else $error("vertical stage lost an item");
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(out_valid) && $stable(s1_valid_ff))
      else $error("vertical pipeline moved while stalled");

endmodule

`default_nettype wire

[rtl/sgb_horiz.sv]
`default_nettype none

module sgb_horiz #(
   parameter int MAX_RADIUS = 7,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              tok_valid,
   input  wire logic [15:0]       tok_value,
   input  wire sgb_pkg::tok_type  tok,
   input  wire logic [2:0]        radius,
   input  wire logic [63:0]       weights_low,
   input  wire logic [63:0]       weights_high,
   output logic                   busy,
   output logic                   push,
   output sgb_pkg::rsp_type       push_data
);

   localparam int TAPS = 2 * MAX_RADIUS + 1;
   localparam int NG = (TAPS + 3) / 4;
   localparam int DW = $clog2(TAPS) + 1;
   localparam logic [sgb_pkg::ACC_BITS-1:0] SAT_MAX =
      (sgb_pkg::ACC_BITS'(1) << SAMPLE_BITS) - sgb_pkg::ACC_BITS'(1);

   logic [15:0] cw_ff [TAPS];
   logic [15:0] cw_in [TAPS];
   logic [2:0]  tail_ff;
   logic [15:0] row_ff;
   logic [9:0]  col_ff;
   logic        fend_ff;

   logic        take;
   logic        tail_step;
   logic        emit;
   sgb_pkg::rsp_type emit_meta;

   logic             h1_valid_ff;
   logic [31:0]      prod_ff [TAPS];
   logic [31:0]      prod_in [TAPS];
   sgb_pkg::rsp_type h1_meta_ff;
   logic             h2_valid_ff;
   logic [sgb_pkg::ACC_BITS-1:0] grp_ff [NG];
   logic [sgb_pkg::ACC_BITS-1:0] grp_in [NG];
   sgb_pkg::rsp_type h2_meta_ff;
   logic [sgb_pkg::ACC_BITS-1:0] total;

   assign busy = (tail_ff != 3'd0);
   assign take = adv && !busy && tok_valid;
   assign tail_step = adv && busy;
   assign emit = (take && tok.emit_main) || tail_step;

   // Shift the column window: a new vertical value, or a zero past the right edge
   always_comb begin
      logic [15:0] base [TAPS];
      for (int j = 0; j < TAPS; j++) begin
         base[j] = (take && tok.clear) ? 16'd0 : cw_ff[j];
      end
      cw_in[0] = take ? tok_value : 16'd0;
      for (int j = 1; j < TAPS; j++) cw_in[j] = base[j-1];
   end

   // Fields of the result produced this cycle
   always_comb begin
      emit_meta.value = 16'd0;
      if (busy) begin
         emit_meta.out_row = row_ff;
         emit_meta.out_col = col_ff + 10'd1;
         emit_meta.last = (tail_ff == 3'd1);
         emit_meta.frame_end = fend_ff && (tail_ff == 3'd1);
      end else begin
         emit_meta.out_row = tok.orow;
         emit_meta.out_col = tok.col;
         emit_meta.last = (tok.tail == 3'd0);
         emit_meta.frame_end = 1'b0;
      end
   end

   // Sequencer: window and pending right-edge outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff <= 3'd0;
         for (int j = 0; j < TAPS; j++) cw_ff[j] <= 16'd0;
      end else begin
         if (take || tail_step) cw_ff <= cw_in;
         if (take) tail_ff <= tok.tail;
         else if (tail_step) tail_ff <= tail_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         row_ff <= tok.orow;
         col_ff <= tok.col;
         fend_ff <= tok.frame_end;
      end else if (tail_step) begin
         col_ff <= col_ff + 10'd1;
      end
   end

   // Weighted taps
   always_comb begin
      logic [DW-1:0] rj;
      logic [DW-1:0] d;
      logic [15:0]   w;
      rj = DW'(radius);
      for (int j = 0; j < TAPS; j++) begin
         d = (DW'(j) > rj) ? (DW'(j) - rj) : (rj - DW'(j));
         w = (DW'(j) <= (rj << 1)) ? sgb_pkg::weight_at(weights_low, weights_high, d[2:0])
                                   : 16'd0;
         prod_in[j] = w * cw_in[j];
      end
   end

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_in[g] = '0;
         for (int i = 0; i < 4; i++) begin
            if (g * 4 + i < TAPS) grp_in[g] = grp_in[g] + sgb_pkg::ACC_BITS'(prod_ff[g*4+i]);
         end
      end
   end

   always_comb begin
      total = '0;
      for (int g = 0; g < NG; g++) total = total + grp_ff[g];
   end

   // Advance the sum pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         h1_valid_ff <= 1'b0;
         h2_valid_ff <= 1'b0;
      end else if (adv) begin
         h1_valid_ff <= emit;
         h2_valid_ff <= h1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         h1_meta_ff <= emit_meta;
         grp_ff <= grp_in;
         h2_meta_ff <= h1_meta_ff;
      end
   end

   // Hand the finished result to the queue
   always_comb begin
      push = adv && h2_valid_ff;
      push_data = h2_meta_ff;
      push_data.value = sgb_pkg::round_sat(total, SAT_MAX);
   end

   assert property (@(posedge clock) disable iff (reset)
      tail_ff <= 3'(MAX_RADIUS))
      else $error("pending edge outputs exceed the radius");
   assert property (@(posedge clock) disable iff (reset)
      adv && busy |=> tail_ff == $past(tail_ff) - 3'd1)
      else $error("edge output count did not step down");

endmodule

`default_nettype wire

[rtl/sgb_out_fifo.sv]
`default_nettype none

module sgb_out_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sgb_pkg::rsp_type  push_data,
   input  wire logic              pop,
   output logic                   full,
   output logic                   valid,
   output sgb_pkg::rsp_type       data
);

   localparam int PW = $clog2(sgb_pkg::OUT_DEPTH);

   sgb_pkg::rsp_type mem [sgb_pkg::OUT_DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [PW:0]   count_ff;

   assign full = (count_ff == (PW+1)'(sgb_pkg::OUT_DEPTH));
   assign valid = (count_ff != '0);
   assign data = mem[rd_ptr_ff];

   // Store results
   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_data;
   end

   // Move pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PW'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + PW'(1);
         if (push && !pop) count_ff <= count_ff + (PW+1)'(1);
         else if (pop && !push) count_ff <= count_ff - (PW+1)'(1);
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("result queue overflow");
   assert property (@(posedge clock) disable iff (reset) pop |-> valid)
      else $error("result queue underflow");

endmodule

`default_nettype wire

[rtl/separable_gaussian_blur.sv]
// Path: vertical s1, s2, s3 and out, horizontal h1 and h2, then the result queue.
// Throughput: one request per cycle while the result queue is not full; the last
// column of an output row adds R right-edge pixels; the horizontal sequencer holds
// requests meanwhile. The line store takes one read and one write per cycle.
// Reset: synchronous; clears counters, column window, queue and pipeline valids and
// loads the control registers with their defaults. The line store is not cleared.
`default_nettype none

module separable_gaussian_blur #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_RADIUS = 7,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [15:0] req_pixel,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_value,
   output logic [15:0]      rsp_out_row,
   output logic [9:0]       rsp_out_col,
   output logic             rsp_last,
   output logic             rsp_frame_end,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int ROW_SLOTS = 2 * MAX_RADIUS;
   localparam int SLW = $clog2(ROW_SLOTS);
   localparam int MWW = $clog2(MAX_WIDTH + 1);
   localparam int WCW = (MWW > 11) ? MWW : 11;
   localparam int CW = (XW > 10) ? XW : 10;
   localparam logic [15:0] SAMPLE_MASK = (SAMPLE_BITS >= 16) ? 16'hFFFF
                                         : 16'((32'd1 << SAMPLE_BITS) - 32'd1);

   logic [10:0] image_width_ff;
   logic [15:0] image_height_ff;
   logic [2:0]  kernel_radius_ff;
   logic [63:0] weights_low_ff;
   logic [63:0] weights_high_ff;

   logic [XW-1:0]  column_count_ff;
   logic [15:0]    row_count_ff;
   logic [2:0]     drain_count_ff;
   logic [SLW-1:0] slot_ff;

   logic [WCW-1:0] w_raw;
   logic [WCW-1:0] w_eff;
   logic [15:0]    h_eff;
   logic [2:0]     r_eff;
   logic [16:0]    r_row;
   logic [16:0]    orow17;
   logic           in_frame;
   logic [15:0]    sample;
   logic           last_col;
   logic           row_ok;
   logic [CW-1:0]  col_wide;
   logic [2:0]     drain_next;
   logic           frame_wrap;
   sgb_pkg::tok_type a_tok;

   logic             adv;
   logic             h_busy;
   logic             accept;
   logic             v_valid;
   logic [15:0]      v_value;
   sgb_pkg::tok_type v_tok;
   logic             push;
   sgb_pkg::rsp_type push_data;
   logic             q_full;
   sgb_pkg::rsp_type q_data;

   assign csr_ready = 1'b1;
   assign req_ready = adv && !h_busy;
   assign accept = req_valid && req_ready;

   // Control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= 11'd640;
         image_height_ff <= 16'd480;
         kernel_radius_ff <= 3'd3;
         weights_low_ff <= 64'h01220DD33DF46621;
         weights_high_ff <= 64'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (sgb_pkg::csr_index_type'(csr_index))
            sgb_pkg::CSR_IMAGE_WIDTH:   image_width_ff <= csr_data[10:0];
            sgb_pkg::CSR_IMAGE_HEIGHT:  image_height_ff <= csr_data[15:0];
            sgb_pkg::CSR_KERNEL_RADIUS: kernel_radius_ff <= csr_data[2:0];
            sgb_pkg::CSR_WEIGHTS_LOW:   weights_low_ff <= csr_data;
            sgb_pkg::CSR_WEIGHTS_HIGH:  weights_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Clamp the frame geometry
   always_comb begin
      w_raw = WCW'(image_width_ff);
      if (w_raw < WCW'(16)) w_eff = WCW'(16);
      else if (w_raw > WCW'(MAX_WIDTH)) w_eff = WCW'(MAX_WIDTH);
      else w_eff = w_raw;
      h_eff = (image_height_ff == 16'd0) ? 16'd1 : image_height_ff;
      if (kernel_radius_ff == 3'd0) r_eff = 3'd1;
      else if (kernel_radius_ff > 3'(MAX_RADIUS)) r_eff = 3'(MAX_RADIUS);
      else r_eff = kernel_radius_ff;
   end

   // Classify the request against the frame position
   always_comb begin
      r_row = 17'(row_count_ff) + 17'(drain_count_ff);
      orow17 = r_row - 17'(r_eff);
      in_frame = (drain_count_ff == 3'd0) && (row_count_ff < h_eff);
      sample = (in_frame && (req_op == sgb_pkg::OP_PIXEL)) ? (req_pixel & SAMPLE_MASK)
                                                            : 16'd0;
      last_col = ((WCW+1)'(column_count_ff) + (WCW+1)'(1)) >= (WCW+1)'(w_eff);
      row_ok = (r_row >= 17'(r_eff)) && (orow17 < 17'(h_eff));
      col_wide = CW'(column_count_ff) - CW'(r_eff);
      drain_next = in_frame ? drain_count_ff : drain_count_ff + 3'd1;
      frame_wrap = (drain_next >= r_eff);
      a_tok.clear = (column_count_ff == '0);
      a_tok.emit_main = row_ok && (column_count_ff >= XW'(r_eff));
      a_tok.tail = (row_ok && last_col) ? r_eff : 3'd0;
      a_tok.frame_end = row_ok && last_col && (orow17 == 17'(h_eff) - 17'd1);
      a_tok.orow = orow17[15:0];
      a_tok.col = col_wide[9:0];
   end

   // Advance column, row, drain and slot position
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff <= 16'd0;
         drain_count_ff <= 3'd0;
         slot_ff <= '0;
      end else if (accept) begin
         if (last_col) begin
            column_count_ff <= '0;
            if (frame_wrap) begin
               row_count_ff <= 16'd0;
               drain_count_ff <= 3'd0;
               slot_ff <= '0;
            end else begin
               if (in_frame) row_count_ff <= row_count_ff + 16'd1;
               drain_count_ff <= drain_next;
               slot_ff <= (slot_ff == SLW'(ROW_SLOTS - 1)) ? '0 : slot_ff + SLW'(1);
            end
         end else begin
            column_count_ff <= column_count_ff + XW'(1);
         end
      end
   end

   sgb_vert #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_RADIUS(MAX_RADIUS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_vert (
      .clock(clock),
      .reset(reset),
      .adv(adv && !h_busy),
      .in_valid(accept),
      .in_addr(column_count_ff),
      .in_slot(slot_ff),
      .in_row(r_row),
      .in_sample(sample),
      .in_radius(r_eff),
      .in_tok(a_tok),
      .weights_low(weights_low_ff),
      .weights_high(weights_high_ff),
      .out_valid(v_valid),
      .out_value(v_value),
      .out_tok(v_tok)
   );

   sgb_horiz #(
      .MAX_RADIUS(MAX_RADIUS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_horiz (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .tok_valid(v_valid),
      .tok_value(v_value),
      .tok(v_tok),
      .radius(r_eff),
      .weights_low(weights_low_ff),
      .weights_high(weights_high_ff),
      .busy(h_busy),
      .push(push),
      .push_data(push_data)
   );

   sgb_out_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .pop(rsp_valid && rsp_ready),
      .full(q_full),
      .valid(rsp_valid),
      .data(q_data)
   );

   // Stall the request side and both filter passes while the result queue is full
   assign adv = !q_full;

   assign rsp_value = q_data.value;
   assign rsp_out_row = q_data.out_row;
   assign rsp_out_col = q_data.out_col;
   assign rsp_last = q_data.last;
   assign rsp_frame_end = q_data.frame_end;

   assert property (@(posedge clock) disable iff (reset) h_busy |-> !req_ready)
      else $error("request taken while edge outputs pending");
   assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLW'(ROW_SLOTS - 1))
      else $error("row slot out of range");

endmodule

`default_nettype wire
